@@ hw/rtl/m3i_pkg.sv @@
// Shared types and constants for the 3x3 matrix inverse block.
`default_nettype none

package m3i_pkg;

   // Number of matrix elements, and so of inverse lanes.
   localparam int NUM_ELEMS = 9;

   // Width of the near-zero threshold register.
   localparam int THR_WIDTH = 31;

   typedef logic [NUM_ELEMS-1:0] m3i_lanes_type;

   // Per-item flags that travel beside the divider lanes.
   typedef struct packed {
      m3i_lanes_type neg;
      m3i_lanes_type ovf;
      logic          sing;
   } m3i_flags_type;

endpackage

`default_nettype wire

@@ hw/rtl/m3i_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
`default_nettype none

module m3i_divider
   import m3i_pkg::*;
#(
   parameter int NUM_W  = 97,
   parameter int DEN_W  = 99,
   parameter int QUO_W  = 32,
   parameter int SIDE_W = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 enable,
   input  wire logic                                 in_valid,
   input  wire logic [NUM_ELEMS-1:0][NUM_W-1:0]      in_num,
   input  wire logic [DEN_W-1:0]                     in_den,
   input  wire m3i_flags_type                        in_flags,
   input  wire logic [SIDE_W-1:0]                    in_side,
   output logic                                      out_valid,
   output logic [NUM_ELEMS-1:0][QUO_W-1:0]           out_quo,
   output m3i_flags_type                             out_flags,
   output logic [SIDE_W-1:0]                         out_side
);

   localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [NUM_ELEMS-1:0][REM_W-1:0] rem_ff   [QUO_W];
   logic [NUM_ELEMS-1:0][QUO_W-1:0] quo_ff   [QUO_W];
   logic [REM_W-1:0]                den_ff   [QUO_W];
   m3i_flags_type                   flags_ff [QUO_W];
   logic [SIDE_W-1:0]               side_ff  [QUO_W];
   logic [QUO_W-1:0]                vld_ff;

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;

      logic [NUM_ELEMS-1:0][REM_W-1:0] src_rem;
      logic [NUM_ELEMS-1:0][QUO_W-1:0] src_quo;
      logic [REM_W-1:0]                src_den;
      m3i_flags_type                   src_flags;
      logic [SIDE_W-1:0]               src_side;
      logic                            src_vld;
      logic [NUM_ELEMS-1:0][REM_W-1:0] rem_in;
      logic [NUM_ELEMS-1:0][QUO_W-1:0] quo_in;
      logic [REM_W-1:0]                shifted_den;

      // The first stage takes the item straight from the inputs.
      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < NUM_ELEMS; l++) begin
               src_rem[l] = REM_W'(in_num[l]);
               src_quo[l] = '0;
            end
            src_den   = REM_W'(in_den);
            src_flags = in_flags;
            src_side  = in_side;
            src_vld   = in_valid;
         end
      end else begin : g_next
         always_comb begin
            src_rem   = rem_ff[s-1];
            src_quo   = quo_ff[s-1];
            src_den   = den_ff[s-1];
            src_flags = flags_ff[s-1];
            src_side  = side_ff[s-1];
            src_vld   = vld_ff[s-1];
         end
      end

      // Trial subtraction of the divisor at this stage's bit weight.
      assign shifted_den = src_den << BIT;

      always_comb begin
         for (int l = 0; l < NUM_ELEMS; l++) begin
            rem_in[l] = src_rem[l];
            quo_in[l] = src_quo[l];
            if (src_rem[l] >= shifted_den) begin
               rem_in[l]      = src_rem[l] - shifted_den;
               quo_in[l][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (enable) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s]   <= rem_in;
            quo_ff[s]   <= quo_in;
            den_ff[s]   <= src_den;
            flags_ff[s] <= src_flags;
            side_ff[s]  <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_flags = flags_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/matrix3x3_inverse.sv @@
// Top level of the 3x3 matrix inverse: cofactors, determinant, threshold and division.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  req     | in        | req_valid/req_ready | nine matrix elements, signed fixed point
//  rsp     | out       | rsp_valid/rsp_ready | nine inverse elements, determinant, flag
//  csr     | in        | csr_valid/csr_ready | near-zero threshold
//
// One item is accepted per cycle while the output is empty or taken; the pipeline is made of
// eight arithmetic stages, one stage per quotient bit in the divider and the output register.
// Reset is synchronous and clears only the valid bits and the threshold (to one).
// When the output item is not taken, the whole pipeline holds and nothing is lost.
// The threshold port is always ready.
`default_nettype none

module matrix3x3_inverse
   import m3i_pkg::*;
#(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [ELEM_WIDTH-1:0] req_a_r1c1,
   input  wire logic signed [ELEM_WIDTH-1:0] req_a_r1c2,
   input  wire logic signed [ELEM_WIDTH-1:0] req_a_r1c3,
   input  wire logic signed [ELEM_WIDTH-1:0] req_a_r2c1,
   input  wire logic signed [ELEM_WIDTH-1:0] req_a_r2c2,
   input  wire logic signed [ELEM_WIDTH-1:0] req_a_r2c3,
   input  wire logic signed [ELEM_WIDTH-1:0] req_a_r3c1,
   input  wire logic signed [ELEM_WIDTH-1:0] req_a_r3c2,
   input  wire logic signed [ELEM_WIDTH-1:0] req_a_r3c3,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [ELEM_WIDTH-1:0]      rsp_i_r1c1,
   output logic signed [ELEM_WIDTH-1:0]      rsp_i_r1c2,
   output logic signed [ELEM_WIDTH-1:0]      rsp_i_r1c3,
   output logic signed [ELEM_WIDTH-1:0]      rsp_i_r2c1,
   output logic signed [ELEM_WIDTH-1:0]      rsp_i_r2c2,
   output logic signed [ELEM_WIDTH-1:0]      rsp_i_r2c3,
   output logic signed [ELEM_WIDTH-1:0]      rsp_i_r3c1,
   output logic signed [ELEM_WIDTH-1:0]      rsp_i_r3c2,
   output logic signed [ELEM_WIDTH-1:0]      rsp_i_r3c3,
   output logic signed [ELEM_WIDTH-1:0]      rsp_det_value,
   output logic                              rsp_singular,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [THR_WIDTH-1:0]         csr_near_zero_threshold
);

   localparam int E     = ELEM_WIDTH;
   localparam int PW    = 2 * E;            // element product
   localparam int CW    = 2 * E + 1;        // cofactor
   localparam int PPW   = 2 * E + 1;        // determinant partial product
   localparam int TW    = 3 * E + 2;        // element times cofactor
   localparam int DW    = 3 * E + 3;        // determinant
   localparam int NMW   = CW + 2 * FRAC_BITS;
   localparam int OVF_W = (NMW > DW + E) ? NMW : DW + E;
   localparam int LW    = (DW > THR_WIDTH + 2 * FRAC_BITS) ? DW : THR_WIDTH + 2 * FRAC_BITS;
   localparam int SAT_W = (E + 1 > DW - 2 * FRAC_BITS) ? E + 1 : DW - 2 * FRAC_BITS;

   localparam logic [E-1:0]     SAT_MIN  = E'(1) << (E - 1);
   localparam logic [E-1:0]     SAT_MAX  = ~SAT_MIN;
   localparam logic [SAT_W-1:0] SAT_HALF = SAT_W'(1) << (E - 1);

   // Clamps a sign and magnitude to the signed element range.
   function automatic logic [E-1:0] sat_mag(input logic neg, input logic [SAT_W-1:0] mag);
      logic [E-1:0] res;
      if (neg) begin
         if (mag > SAT_HALF) res = SAT_MIN;
         else                res = ~mag[E-1:0] + E'(1);
      end else begin
         if (mag >= SAT_HALF) res = SAT_MAX;
         else                 res = mag[E-1:0];
      end
      return res;
   endfunction

   logic pipe_advance;
   logic [THR_WIDTH-1:0] thr_ff;

   logic signed [E-1:0]   req_elem [NUM_ELEMS];

   logic signed [E-1:0]   m_ff      [NUM_ELEMS];
   logic signed [PW-1:0]  pa_ff     [NUM_ELEMS];
   logic signed [PW-1:0]  pb_ff     [NUM_ELEMS];
   logic signed [E-1:0]   m1_s2_ff  [3];
   logic signed [E-1:0]   m1_s3_ff  [3];
   logic signed [CW-1:0]  cof_ff    [NUM_ELEMS];
   logic signed [CW-1:0]  cof_s4_ff [NUM_ELEMS];
   logic signed [CW-1:0]  cof_s5_ff [NUM_ELEMS];
   logic signed [CW-1:0]  cof_s6_ff [NUM_ELEMS];
   logic signed [PPW-1:0] pp_lo_ff  [3];
   logic signed [PPW-1:0] pp_hi_ff  [3];
   logic signed [TW-1:0]  term_ff   [3];
   logic signed [DW-1:0]  det_ff;
   logic [DW-1:0]         det_bits;
   logic [DW-1:0]         det_mag_ff;
   logic                  det_neg_ff;
   logic [CW-1:0]         cof_bits  [NUM_ELEMS];
   logic [CW-1:0]         cof_mag_ff [NUM_ELEMS];
   logic [NUM_ELEMS-1:0]  cof_neg_ff;
   logic [7:0]            vld_ff;

   logic [NUM_ELEMS-1:0][NMW-1:0] num_ff;
   logic [DW-1:0]                 den_ff;
   m3i_flags_type                 flags_ff;
   logic [E-1:0]                  detv_ff;

   logic                          div_valid;
   logic [NUM_ELEMS-1:0][E-1:0]   div_quo;
   m3i_flags_type                 div_flags;
   logic [E-1:0]                  div_detv;

   logic                          rsp_valid_ff;
   logic [E-1:0]                  rsp_inv_ff [NUM_ELEMS];
   logic [E-1:0]                  rsp_det_ff;
   logic                          rsp_sing_ff;

   // The pipeline moves whenever the output register is empty or being emptied.
   assign pipe_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready    = pipe_advance;
   assign csr_ready    = 1'b1;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_WIDTH'(1);
      end else if (csr_valid) begin
         thr_ff <= csr_near_zero_threshold;
      end
   end

   assign req_elem[0] = req_a_r1c1;
   assign req_elem[1] = req_a_r1c2;
   assign req_elem[2] = req_a_r1c3;
   assign req_elem[3] = req_a_r2c1;
   assign req_elem[4] = req_a_r2c2;
   assign req_elem[5] = req_a_r2c3;
   assign req_elem[6] = req_a_r3c1;
   assign req_elem[7] = req_a_r3c2;
   assign req_elem[8] = req_a_r3c3;

   // Valid bits of the arithmetic stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_advance) begin
         vld_ff <= {vld_ff[6:0], req_valid};
      end
   end

   // Input register, the two products of every cofactor, and the cofactor with its delays.
   for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_cof
      localparam int I1 = ((k / 3) + 1) % 3;
      localparam int I2 = ((k / 3) + 2) % 3;
      localparam int J1 = ((k % 3) + 1) % 3;
      localparam int J2 = ((k % 3) + 2) % 3;

      always_ff @(posedge clock) begin
         if (pipe_advance) begin
            m_ff[k]      <= req_elem[k];
            pa_ff[k]     <= m_ff[I1*3+J1] * m_ff[I2*3+J2];
            pb_ff[k]     <= m_ff[I1*3+J2] * m_ff[I2*3+J1];
            cof_ff[k]    <= CW'(pa_ff[k]) - CW'(pb_ff[k]);
            cof_s4_ff[k] <= cof_ff[k];
            cof_s5_ff[k] <= cof_s4_ff[k];
            cof_s6_ff[k] <= cof_s5_ff[k];
         end
      end
   end

   // Determinant along the first row, with the wide cofactor split in two slices.
   for (genvar j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clock) begin
         if (pipe_advance) begin
            m1_s2_ff[j] <= m_ff[j];
            m1_s3_ff[j] <= m1_s2_ff[j];
            pp_lo_ff[j] <= m1_s3_ff[j] * $signed({1'b0, cof_ff[j][E-1:0]});
            pp_hi_ff[j] <= m1_s3_ff[j] * $signed(cof_ff[j][CW-1:E]);
            term_ff[j]  <= (TW'(pp_hi_ff[j]) <<< E) + TW'(pp_lo_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         det_ff <= DW'(term_ff[0]) + DW'(term_ff[1]) + DW'(term_ff[2]);
      end
   end

   // Magnitudes and signs of the determinant and the cofactors.
   assign det_bits = det_ff;

   always_comb begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
         cof_bits[k] = cof_s6_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         det_neg_ff <= det_bits[DW-1];
         det_mag_ff <= det_bits[DW-1] ? (~det_bits + DW'(1)) : det_bits;
         for (int k = 0; k < NUM_ELEMS; k++) begin
            cof_neg_ff[k] <= cof_bits[k][CW-1];
            cof_mag_ff[k] <= cof_bits[k][CW-1] ? (~cof_bits[k] + CW'(1)) : cof_bits[k];
         end
      end
   end

   // Threshold test, overflow tests, lane signs, divider operands and the saturated
   // determinant. Inverse lane (r, c) takes the cofactor of (c, r).
   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         flags_ff.sing <= LW'(det_mag_ff) <= (LW'(thr_ff) << (2 * FRAC_BITS));
         detv_ff       <= sat_mag(det_neg_ff, SAT_W'(det_mag_ff >> (2 * FRAC_BITS)));
         den_ff        <= det_mag_ff;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               num_ff[r*3+c]       <= NMW'(cof_mag_ff[c*3+r]) << (2 * FRAC_BITS);
               flags_ff.neg[r*3+c] <= cof_neg_ff[c*3+r] ^ det_neg_ff;
               flags_ff.ovf[r*3+c] <= (OVF_W'(cof_mag_ff[c*3+r]) << (2 * FRAC_BITS))
                                      >= (OVF_W'(det_mag_ff) << E);
            end
         end
      end
   end

   m3i_divider #(
      .NUM_W  (NMW),
      .DEN_W  (DW),
      .QUO_W  (E),
      .SIDE_W (E)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_advance),
      .in_valid  (vld_ff[7]),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_flags  (flags_ff),
      .in_side   (detv_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_flags (div_flags),
      .out_side  (div_detv)
   );

   // Output register: sign, saturation and zeroing of a singular item.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         rsp_det_ff  <= div_detv;
         rsp_sing_ff <= div_flags.sing;
         for (int l = 0; l < NUM_ELEMS; l++) begin
            if (div_flags.sing) begin
               rsp_inv_ff[l] <= '0;
            end else if (div_flags.ovf[l]) begin
               rsp_inv_ff[l] <= sat_mag(div_flags.neg[l], '1);
            end else begin
               rsp_inv_ff[l] <= sat_mag(div_flags.neg[l], SAT_W'(div_quo[l]));
            end
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_i_r1c1    = rsp_inv_ff[0];
   assign rsp_i_r1c2    = rsp_inv_ff[1];
   assign rsp_i_r1c3    = rsp_inv_ff[2];
   assign rsp_i_r2c1    = rsp_inv_ff[3];
   assign rsp_i_r2c2    = rsp_inv_ff[4];
   assign rsp_i_r2c3    = rsp_inv_ff[5];
   assign rsp_i_r3c1    = rsp_inv_ff[6];
   assign rsp_i_r3c2    = rsp_inv_ff[7];
   assign rsp_i_r3c3    = rsp_inv_ff[8];
   assign rsp_det_value = rsp_det_ff;
   assign rsp_singular  = rsp_sing_ff;

endmodule

`default_nettype wire
